### rtl/nuga_pkg.sv
// Shared constants, codes and types of the nearest-neighbour upsample gradient accumulator.
// Used by nuga_div, nuga_store and nearest_upsample_grad_accumulate; depends on nothing.
package nuga_pkg;

  localparam int unsigned PLANES      = 4;
  localparam int unsigned MAX_IN_H    = 32;
  localparam int unsigned MAX_IN_W    = 32;
  localparam int unsigned MAX_OUT_DIM = 128;

  localparam int unsigned STORE_DEPTH = PLANES * MAX_IN_H * MAX_IN_W;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ENTRY_W     = DATA_W + 1;

  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned SMALL_W    = 6;
  localparam int unsigned BIG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned MAX_IN = (MAX_IN_H > MAX_IN_W) ? MAX_IN_H : MAX_IN_W;
  localparam int unsigned QUOT_W = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int unsigned STEP_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;
  localparam int unsigned NUM_W  = POS_W + SMALL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_HEIGHT,
    CFG_IN_WIDTH,
    CFG_OUT_HEIGHT,
    CFG_OUT_WIDTH
  } nuga_cfg_e;

  typedef enum logic {
    OP_ACCUMULATE,
    OP_READ
  } nuga_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_DIV,
    ST_COL_DIV,
    ST_UPDATE,
    ST_RESPOND
  } nuga_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [BIG_W-1:0] den;
  } nuga_div_req_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } nuga_mem_req_t;

endpackage

### rtl/nearest_upsample_grad_accumulate.sv
// Top level of the nearest-neighbour upsample gradient accumulator: sequencer and registers.
// Depends on nuga_pkg, nuga_div and nuga_store.
//
//   channel   direction  ports                                   handshake
//   request   in         operation, plane, row, col, grad_value  start high, busy low
//   result    out        sum_value, saturated                    out_strobe_o, one cycle
//   config    in         cfg_idx_i, cfg_data_i                   cfg_we_i
//
// An accumulate request keeps busy high while it runs, so no new request is taken meanwhile:
// two five-step divisions on the shared divider, then a read-modify-write of the store.
// A read request returns its result in the next cycle; busy stays high until the result is shown.
// After reset a clearing pass over all 4096 entries holds busy high; configuration is still taken.
// The receiver cannot stall, so a result is shown for exactly one cycle.
module nearest_upsample_grad_accumulate
  import nuga_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [PLANE_W-1:0]    plane_i,
  input  logic [POS_W-1:0]      row_i,
  input  logic [POS_W-1:0]      col_i,
  input  logic signed [DATA_W-1:0] grad_value_i,
  output logic                  out_strobe_o,
  output logic signed [DATA_W-1:0] sum_value_o,
  output logic                  saturated_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  nuga_state_e state_q, state_d;

  logic [SMALL_W-1:0] in_h_q, in_w_q, ih_eff, iw_eff;
  logic [BIG_W-1:0]   out_h_q, out_w_q, oh_eff, ow_eff;

  logic [PLANE_W-1:0] plane_q;
  logic [POS_W-1:0]   col_q;
  logic [DATA_W-1:0]  grad_q;
  logic [QUOT_W-1:0]  sr_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               hit_q;

  logic               accept, acc_hit, rd_hit, is_read;
  logic [NUM_W-1:0]   row_prod, col_prod;

  nuga_div_req_t      div_req;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;

  nuga_mem_req_t      mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_ready;

  logic [DATA_W:0]    sum_wide;
  logic               ovf;
  logic [DATA_W-1:0]  sum_sat;

  function automatic logic [ADDR_W-1:0] entry_addr(logic [PLANE_W-1:0] p,
                                                   logic [POS_W-1:0] r,
                                                   logic [POS_W-1:0] c);
    return ADDR_W'((32'(p) * MAX_IN_H + 32'(r)) * MAX_IN_W + 32'(c));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_h_q  <= SMALL_W'(32);
      in_w_q  <= SMALL_W'(32);
      out_h_q <= BIG_W'(64);
      out_w_q <= BIG_W'(64);
    end else if (cfg_we_i) begin
      unique case (nuga_cfg_e'(cfg_idx_i))
        CFG_IN_HEIGHT:  in_h_q  <= cfg_data_i[SMALL_W-1:0];
        CFG_IN_WIDTH:   in_w_q  <= cfg_data_i[SMALL_W-1:0];
        CFG_OUT_HEIGHT: out_h_q <= cfg_data_i[BIG_W-1:0];
        CFG_OUT_WIDTH:  out_w_q <= cfg_data_i[BIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ih_eff = in_h_q;
    if (in_h_q == '0) ih_eff = SMALL_W'(1);
    else if (32'(in_h_q) > MAX_IN_H) ih_eff = SMALL_W'(MAX_IN_H);
    iw_eff = in_w_q;
    if (in_w_q == '0) iw_eff = SMALL_W'(1);
    else if (32'(in_w_q) > MAX_IN_W) iw_eff = SMALL_W'(MAX_IN_W);
    oh_eff = out_h_q;
    if (out_h_q == '0) oh_eff = BIG_W'(1);
    else if (32'(out_h_q) > MAX_OUT_DIM) oh_eff = BIG_W'(MAX_OUT_DIM);
    ow_eff = out_w_q;
    if (out_w_q == '0) ow_eff = BIG_W'(1);
    else if (32'(out_w_q) > MAX_OUT_DIM) ow_eff = BIG_W'(MAX_OUT_DIM);
  end

  assign busy     = (state_q != ST_IDLE) || !mem_ready;
  assign accept   = start && !busy;
  assign is_read  = (nuga_op_e'(operation_i) == OP_READ);
  assign acc_hit  = (32'(plane_i) < PLANES) && (BIG_W'(row_i) < oh_eff)
                    && (BIG_W'(col_i) < ow_eff);
  assign rd_hit   = (32'(plane_i) < PLANES) && (BIG_W'(row_i) < BIG_W'(ih_eff))
                    && (BIG_W'(col_i) < BIG_W'(iw_eff));
  assign row_prod = NUM_W'(row_i) * NUM_W'(ih_eff);
  assign col_prod = NUM_W'(col_q) * NUM_W'(iw_eff);

  always_comb begin
    sum_wide = {mem_rdata[DATA_W-1], mem_rdata[DATA_W-1:0]} + {grad_q[DATA_W-1], grad_q};
    ovf      = sum_wide[DATA_W] ^ sum_wide[DATA_W-1];
    sum_sat  = sum_wide[DATA_W-1:0];
    if (ovf) begin
      sum_sat = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    div_req = '0;
    mem_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_read) begin
            mem_req.rd_en = rd_hit;
            mem_req.addr  = entry_addr(plane_i, row_i, col_i);
            state_d       = ST_RESPOND;
          end else if (acc_hit) begin
            div_req.start = 1'b1;
            div_req.num   = row_prod;
            div_req.den   = oh_eff;
            state_d       = ST_ROW_DIV;
          end
        end
      end
      ST_ROW_DIV: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.num   = col_prod;
          div_req.den   = ow_eff;
          state_d       = ST_COL_DIV;
        end
      end
      ST_COL_DIV: begin
        if (div_done) begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = entry_addr(plane_q, POS_W'(sr_q), POS_W'(div_quot));
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = addr_q;
        mem_req.wdata = {mem_rdata[DATA_W] | ovf, sum_sat};
        state_d       = ST_IDLE;
      end
      ST_RESPOND: begin
        mem_req.wr_en = hit_q;
        mem_req.addr  = addr_q;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      plane_q <= plane_i;
      col_q   <= col_i;
      grad_q  <= grad_value_i;
      hit_q   <= rd_hit;
      addr_q  <= entry_addr(plane_i, row_i, col_i);
    end
    if (state_q == ST_ROW_DIV && div_done) begin
      sr_q <= div_quot;
    end
    if (state_q == ST_COL_DIV && div_done) begin
      addr_q <= entry_addr(plane_q, POS_W'(sr_q), POS_W'(div_quot));
    end
  end

  nuga_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  nuga_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .ready_o (mem_ready)
  );

  assign out_strobe_o = (state_q == ST_RESPOND);
  assign sum_value_o  = hit_q ? $signed(mem_rdata[DATA_W-1:0]) : '0;
  assign saturated_o  = hit_q & mem_rdata[DATA_W];

  a_strobe_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(start && !busy && operation_i))
    else $error("result strobe without a preceding read request");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == ST_UPDATE || state_q == ST_RESPOND))
    else $error("store written outside the update or respond step");

  a_div_done_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_ROW_DIV || state_q == ST_COL_DIV))
    else $error("divider finished while the sequencer was not waiting");

  a_update_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> ($past(state_q) == ST_COL_DIV))
    else $error("update step not preceded by the column division");

endmodule

### rtl/nuga_div.sv
// Shared restoring divider: one quotient bit per cycle, for quotients below MAX_IN.
// Depends on nuga_pkg.
module nuga_div
  import nuga_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nuga_div_req_t       req_i,
  output logic                done_o,
  output logic [QUOT_W-1:0]   quot_o
);

  logic [NUM_W-1:0]        rem_q, rem_d;
  logic [BIG_W-1:0]        den_q, den_d;
  logic [QUOT_W-1:0]       quot_q, quot_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [NUM_W+QUOT_W-1:0] trial;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = (NUM_W + QUOT_W)'(den_q) << step_q;
    if (req_i.start) begin
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quot_d = '0;
      step_d = STEP_W'(QUOT_W - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      if ((NUM_W + QUOT_W)'(rem_q) >= trial) begin
        rem_d          = rem_q - NUM_W'(trial);
        quot_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    step_q <= step_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/nuga_store.sv
// Gradient store with sticky clip marks, one read port and one write port, registered read data.
// Sweeps every entry to zero after reset. Depends on nuga_pkg.
module nuga_store
  import nuga_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nuga_mem_req_t      req_i,
  output logic [ENTRY_W-1:0] rdata_o,
  output logic               ready_o
);

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic               clearing_q, clearing_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clearing_q;

endmodule
